FILE: sv/hclb_pkg.sv
// hclb_pkg: shared types and constants for the huffman code length builder
// used by hclb_ctrl, hclb_dp and huffman_code_length_builder_unit; no dependencies
package hclb_pkg;

    // default sizing
    localparam int MAX_SYMBOLS_DEF = 1024;
    localparam int WEIGHT_BITS_DEF = 32;

    // fixed port widths
    localparam int IN_W  = 32;
    localparam int SYM_W = 11;
    localparam int LEN_W = 10;

    // controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_S_INIT,
        ST_S_OUTER,
        ST_S_GETV,
        ST_S_INNER,
        ST_S_CMP,
        ST_B_INIT,
        ST_B_RD,
        ST_B_PICK,
        ST_B_WR1,
        ST_B_WR2,
        ST_D_INIT,
        ST_D_RDP,
        ST_D_RDD,
        ST_D_WR,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        state_t phase;
        logic   load;
        logic   finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic few;
        logic i_done;
        logic j_zero;
        logic cmp_gt;
        logic second;
        logic merge_last;
        logic nd_zero;
        logic out_free;
    } status_t;

endpackage

FILE: sv/hclb_ram.sv
// hclb_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module hclb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/hclb_ctrl.sv
// hclb_ctrl: sequencing state machine for load, sort, tree build and depth pass
// depends on hclb_pkg
module hclb_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    input  hclb_pkg::status_t st,
    output hclb_pkg::cmd_t    cmd
);

    hclb_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hclb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd.phase  = state_reg;
        cmd.load   = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            hclb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_last) state_next = hclb_pkg::ST_CHECK;
                end
            end
            hclb_pkg::ST_CHECK:
                state_next = st.few ? hclb_pkg::ST_DONE : hclb_pkg::ST_S_INIT;
            hclb_pkg::ST_S_INIT:  state_next = hclb_pkg::ST_S_OUTER;
            hclb_pkg::ST_S_OUTER:
                state_next = st.i_done ? hclb_pkg::ST_B_INIT : hclb_pkg::ST_S_GETV;
            hclb_pkg::ST_S_GETV:  state_next = hclb_pkg::ST_S_INNER;
            hclb_pkg::ST_S_INNER:
                state_next = st.j_zero ? hclb_pkg::ST_S_OUTER : hclb_pkg::ST_S_CMP;
            hclb_pkg::ST_S_CMP:
                state_next = st.cmp_gt ? hclb_pkg::ST_S_INNER : hclb_pkg::ST_S_OUTER;
            hclb_pkg::ST_B_INIT:  state_next = hclb_pkg::ST_B_RD;
            hclb_pkg::ST_B_RD:    state_next = hclb_pkg::ST_B_PICK;
            hclb_pkg::ST_B_PICK:
                state_next = st.second ? hclb_pkg::ST_B_WR1 : hclb_pkg::ST_B_RD;
            hclb_pkg::ST_B_WR1:   state_next = hclb_pkg::ST_B_WR2;
            hclb_pkg::ST_B_WR2:
                state_next = st.merge_last ? hclb_pkg::ST_D_INIT : hclb_pkg::ST_B_RD;
            hclb_pkg::ST_D_INIT:  state_next = hclb_pkg::ST_D_RDP;
            hclb_pkg::ST_D_RDP:
                state_next = st.nd_zero ? hclb_pkg::ST_DONE : hclb_pkg::ST_D_RDD;
            hclb_pkg::ST_D_RDD:   state_next = hclb_pkg::ST_D_WR;
            hclb_pkg::ST_D_WR:    state_next = hclb_pkg::ST_D_RDP;
            hclb_pkg::ST_DONE: begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = hclb_pkg::ST_IDLE;
                end
            end
            default: state_next = hclb_pkg::ST_IDLE;
        endcase
    end

endmodule

FILE: sv/hclb_dp.sv
// hclb_dp: weight store, insertion sort, two-queue merge, depth pass and result register
// depends on hclb_pkg and hclb_ram
module hclb_dp #(
    parameter int MAX_SYMBOLS = hclb_pkg::MAX_SYMBOLS_DEF,
    parameter int WEIGHT_BITS = hclb_pkg::WEIGHT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hclb_pkg::cmd_t              cmd,
    output hclb_pkg::status_t           st,
    input  logic [hclb_pkg::IN_W-1:0]   s_weight,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hclb_pkg::SYM_W-1:0]  m_symbol_count,
    output logic [hclb_pkg::LEN_W-1:0]  m_min_length,
    output logic [hclb_pkg::LEN_W-1:0]  m_max_length,
    output logic                        m_overflow
);

    localparam int IDX_W   = $clog2(MAX_SYMBOLS);
    localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int NODE_W  = $clog2(2 * MAX_SYMBOLS);
    localparam int DEPTH_W = $clog2(MAX_SYMBOLS);
    localparam int MW      = WEIGHT_BITS + $clog2(MAX_SYMBOLS);

    // control registers
    logic [CNT_W-1:0] cnt_reg;
    logic             ovf_reg;
    logic             m_valid_reg;

    // working registers
    logic [CNT_W-1:0]       i_reg, j_reg, lh_reg, mh_reg, mc_reg;
    logic [WEIGHT_BITS-1:0] v_reg;
    logic                   take_reg;
    logic [MW-1:0]          wa_reg, wb_reg;
    logic [NODE_W-1:0]      a_reg, b_reg, nd_reg;
    logic [DEPTH_W-1:0]     lo_reg, hi_reg;
    logic [hclb_pkg::SYM_W-1:0] m_count_reg;
    logic [hclb_pkg::LEN_W-1:0] m_min_reg, m_max_reg;
    logic                       m_ovf_reg;

    // memory ports
    logic                   leaf_we;
    logic [IDX_W-1:0]       leaf_waddr, leaf_raddr;
    logic [WEIGHT_BITS-1:0] leaf_wdata, leaf_rdata;
    logic                   mrg_we;
    logic [MW-1:0]          mrg_rdata;
    logic                   par_we;
    logic [NODE_W-1:0]      par_waddr, par_rdata, par_raddr;
    logic                   dep_we;
    logic [NODE_W-1:0]      dep_waddr;
    logic [DEPTH_W-1:0]     dep_wdata, dep_rdata;

    // derived values
    logic [CNT_W-1:0]   jm1;
    logic [NODE_W-1:0]  ndm1, root, mc_node, pick_node;
    logic               use_leaf, cmp_gt, leaf_full;
    logic [MW-1:0]      pick_w;
    logic [DEPTH_W-1:0] dep_inc;

    assign jm1       = j_reg - CNT_W'(1);
    assign ndm1      = nd_reg - NODE_W'(1);
    assign root      = (NODE_W'(cnt_reg) << 1) - NODE_W'(2);
    assign mc_node   = NODE_W'(cnt_reg) + NODE_W'(mc_reg);
    assign cmp_gt    = leaf_rdata > v_reg;
    assign leaf_full = cnt_reg >= CNT_W'(MAX_SYMBOLS);
    assign dep_inc   = dep_rdata + DEPTH_W'(1);

    // queue head selection, ties go to the merged queue
    assign use_leaf  = (lh_reg < cnt_reg)
                     && ((mh_reg >= mc_reg) || (MW'(leaf_rdata) < mrg_rdata));
    assign pick_w    = use_leaf ? MW'(leaf_rdata) : mrg_rdata;
    assign pick_node = use_leaf ? NODE_W'(lh_reg) : NODE_W'(cnt_reg) + NODE_W'(mh_reg);

    // status
    assign st.few        = cnt_reg < CNT_W'(2);
    assign st.i_done     = i_reg >= cnt_reg;
    assign st.j_zero     = j_reg == '0;
    assign st.cmp_gt     = cmp_gt;
    assign st.second     = take_reg;
    assign st.merge_last = mc_reg == cnt_reg - CNT_W'(2);
    assign st.nd_zero    = nd_reg == '0;
    assign st.out_free   = !m_valid_reg || m_ready;

    // leaf memory port steering
    always_comb begin
        leaf_we    = cmd.load && !leaf_full;
        leaf_waddr = cnt_reg[IDX_W-1:0];
        leaf_wdata = WEIGHT_BITS'(s_weight);
        leaf_raddr = i_reg[IDX_W-1:0];
        case (cmd.phase)
            hclb_pkg::ST_S_INNER: begin
                if (j_reg == '0) begin
                    leaf_we    = 1'b1;
                    leaf_waddr = j_reg[IDX_W-1:0];
                    leaf_wdata = v_reg;
                end else begin
                    leaf_raddr = jm1[IDX_W-1:0];
                end
            end
            hclb_pkg::ST_S_CMP: begin
                leaf_we    = 1'b1;
                leaf_waddr = j_reg[IDX_W-1:0];
                leaf_wdata = cmp_gt ? leaf_rdata : v_reg;
            end
            hclb_pkg::ST_B_RD: leaf_raddr = lh_reg[IDX_W-1:0];
            default: ;
        endcase
    end

    // tree memory port steering
    assign mrg_we    = cmd.phase == hclb_pkg::ST_B_WR1;
    assign par_we    = (cmd.phase == hclb_pkg::ST_B_WR1) || (cmd.phase == hclb_pkg::ST_B_WR2);
    assign par_waddr = (cmd.phase == hclb_pkg::ST_B_WR1) ? a_reg : b_reg;
    assign par_raddr = ndm1;
    assign dep_we    = (cmd.phase == hclb_pkg::ST_D_INIT) || (cmd.phase == hclb_pkg::ST_D_WR);
    assign dep_waddr = (cmd.phase == hclb_pkg::ST_D_INIT) ? root : ndm1;
    assign dep_wdata = (cmd.phase == hclb_pkg::ST_D_INIT) ? '0 : dep_inc;

    hclb_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_SYMBOLS)) u_leaf (
        .aclk(aclk), .we(leaf_we), .waddr(leaf_waddr), .wdata(leaf_wdata),
        .raddr(leaf_raddr), .rdata(leaf_rdata)
    );

    hclb_ram #(.WIDTH(MW), .DEPTH(MAX_SYMBOLS)) u_merged (
        .aclk(aclk), .we(mrg_we), .waddr(mc_reg[IDX_W-1:0]), .wdata(wa_reg + wb_reg),
        .raddr(mh_reg[IDX_W-1:0]), .rdata(mrg_rdata)
    );

    hclb_ram #(.WIDTH(NODE_W), .DEPTH(2 * MAX_SYMBOLS)) u_parent (
        .aclk(aclk), .we(par_we), .waddr(par_waddr), .wdata(mc_node),
        .raddr(par_raddr), .rdata(par_rdata)
    );

    hclb_ram #(.WIDTH(DEPTH_W), .DEPTH(2 * MAX_SYMBOLS)) u_depth (
        .aclk(aclk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
        .raddr(par_rdata), .rdata(dep_rdata)
    );

    // count, overflow flag and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b1;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (cmd.load) begin
                if (!leaf_full) cnt_reg <= cnt_reg + CNT_W'(1);
                else            ovf_reg <= 1'b1;
            end
        end
    end

    // sort, merge and depth working registers
    always_ff @(posedge aclk) begin
        case (cmd.phase)
            hclb_pkg::ST_S_INIT: i_reg <= CNT_W'(1);
            hclb_pkg::ST_S_GETV: begin
                v_reg <= leaf_rdata;
                j_reg <= i_reg;
            end
            hclb_pkg::ST_S_INNER: if (j_reg == '0) i_reg <= i_reg + CNT_W'(1);
            hclb_pkg::ST_S_CMP: begin
                if (cmp_gt) j_reg <= jm1;
                else        i_reg <= i_reg + CNT_W'(1);
            end
            hclb_pkg::ST_B_INIT: begin
                lh_reg   <= '0;
                mh_reg   <= '0;
                mc_reg   <= '0;
                take_reg <= 1'b0;
            end
            hclb_pkg::ST_B_PICK: begin
                if (use_leaf) lh_reg <= lh_reg + CNT_W'(1);
                else          mh_reg <= mh_reg + CNT_W'(1);
                if (!take_reg) begin
                    wa_reg <= pick_w;
                    a_reg  <= pick_node;
                end else begin
                    wb_reg <= pick_w;
                    b_reg  <= pick_node;
                end
                take_reg <= !take_reg;
            end
            hclb_pkg::ST_B_WR2: mc_reg <= mc_reg + CNT_W'(1);
            hclb_pkg::ST_D_INIT: begin
                nd_reg <= root;
                lo_reg <= '1;
                hi_reg <= '0;
            end
            hclb_pkg::ST_D_WR: begin
                nd_reg <= ndm1;
                if (ndm1 < NODE_W'(cnt_reg)) begin
                    if (dep_inc < lo_reg) lo_reg <= dep_inc;
                    if (dep_inc > hi_reg) hi_reg <= dep_inc;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_count_reg <= hclb_pkg::SYM_W'(cnt_reg);
            m_min_reg   <= st.few ? '0 : hclb_pkg::LEN_W'(lo_reg);
            m_max_reg   <= st.few ? '0 : hclb_pkg::LEN_W'(hi_reg);
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_symbol_count = m_count_reg;
    assign m_min_length   = m_min_reg;
    assign m_max_length   = m_max_reg;
    assign m_overflow     = m_ovf_reg;

endmodule

FILE: sv/huffman_code_length_builder_unit.sv
// huffman_code_length_builder_unit: weights load one per cycle while idle; after the last
// one the block, unless fewer than two were loaded, sorts (insertion sort), builds the tree
// (n-1 merges, each two picks then two writes) and walks parent links (2n-2 nodes)
// through single-port-read memories, then registers one result; s_ready is low meanwhile.
// reset: synchronous active-low aresetn clears count, overflow flag, state and result valid;
// memories are not cleared and need no clearing pass
module huffman_code_length_builder_unit #(
    parameter int MAX_SYMBOLS = hclb_pkg::MAX_SYMBOLS_DEF,
    parameter int WEIGHT_BITS = hclb_pkg::WEIGHT_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hclb_pkg::IN_W-1:0]   s_weight,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hclb_pkg::SYM_W-1:0]  m_symbol_count,
    output logic [hclb_pkg::LEN_W-1:0]  m_min_length,
    output logic [hclb_pkg::LEN_W-1:0]  m_max_length,
    output logic                        m_overflow
);

    hclb_pkg::cmd_t    cmd;
    hclb_pkg::status_t st;

    hclb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_last(s_last),
        .s_ready(s_ready), .st(st), .cmd(cmd)
    );

    hclb_dp #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .st(st), .s_weight(s_weight),
        .m_valid(m_valid), .m_ready(m_ready), .m_symbol_count(m_symbol_count),
        .m_min_length(m_min_length), .m_max_length(m_max_length), .m_overflow(m_overflow)
    );

`ifndef SYNTHESIS
    // shortest code never exceeds longest
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_min_length <= m_max_length))
        else $error("min_length above max_length");

    // overflow only with a full store
    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |-> (m_symbol_count == hclb_pkg::SYM_W'(MAX_SYMBOLS)))
        else $error("overflow without full symbol store");

    // fewer than two symbols give zero lengths
    a_few_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_symbol_count < hclb_pkg::SYM_W'(2))) |-> (m_max_length == '0))
        else $error("nonzero length for a single symbol");

    // s_ready drops once the last weight is taken, as the build starts
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> !s_ready)
        else $error("input accepted during build");
`endif

endmodule

FILE: bench/tb_huffman_code_length_builder_unit.sv
// tb_huffman_code_length_builder_unit: self-checking bench for the huffman code length builder
// drives weight transactions, predicts code lengths with a two-queue tree build, checks results
// depends on hclb_pkg and huffman_code_length_builder_unit
module tb_huffman_code_length_builder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = hclb_pkg::MAX_SYMBOLS_DEF;

    typedef struct packed {
        logic [hclb_pkg::SYM_W-1:0] count;
        logic [hclb_pkg::LEN_W-1:0] shortest;
        logic [hclb_pkg::LEN_W-1:0] longest;
        logic                       ovf;
    } lengths_t;

    typedef struct {
        logic [hclb_pkg::IN_W-1:0] weight;
        logic                      last;
        bit                        typed;
        lengths_t                  want;
    } stim_row_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [hclb_pkg::IN_W-1:0]   s_weight = '0;
    logic                        s_last = 1'b0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [hclb_pkg::SYM_W-1:0]  m_symbol_count;
    logic [hclb_pkg::LEN_W-1:0]  m_min_length;
    logic [hclb_pkg::LEN_W-1:0]  m_max_length;
    logic                        m_overflow;

    lengths_t                    pending_lengths[$];
    logic [hclb_pkg::IN_W-1:0]   loaded_weights[$];
    bit                          set_overflow = 1'b0;
    bit                          calm = 1'b0;
    bit                          hold_req = 1'b0;
    int                          mismatches = 0;

    huffman_code_length_builder_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_weight(s_weight), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_symbol_count(m_symbol_count),
        .m_min_length(m_min_length), .m_max_length(m_max_length), .m_overflow(m_overflow)
    );

    always #5 aclk = ~aclk;

    // two-queue huffman build over the loaded weights, ties go to the merged queue
    function automatic void huffman_lengths(input logic [hclb_pkg::IN_W-1:0] w[$],
                                            output int shortest, output int longest);
        logic [63:0] leaf[2*CAPACITY];
        logic [63:0] merged[2*CAPACITY];
        int          parent[2*CAPACITY];
        int          depth[2*CAPACITY];
        int          pick[2];
        logic [63:0] pw[2];
        int          n, lh, mh, mc, i, j, k;
        logic [63:0] v;
        bit          from_leaf;
        n = w.size();
        shortest = 0;
        longest = 0;
        if (n < 2) return;
        for (i = 0; i < n; i++) leaf[i] = {32'd0, w[i]};
        // insertion sort ascending
        for (i = 1; i < n; i++) begin
            v = leaf[i];
            j = i;
            while (j > 0 && leaf[j-1] > v) begin
                leaf[j] = leaf[j-1];
                j--;
            end
            leaf[j] = v;
        end
        lh = 0; mh = 0; mc = 0;
        while (lh < n || (mc - mh) > 1) begin
            for (k = 0; k < 2; k++) begin
                if (lh >= n) from_leaf = 1'b0;
                else if (mh >= mc) from_leaf = 1'b1;
                else from_leaf = leaf[lh] < merged[mh];
                if (from_leaf) begin
                    pw[k] = leaf[lh];
                    pick[k] = lh;
                    lh++;
                end else begin
                    pw[k] = merged[mh];
                    pick[k] = n + mh;
                    mh++;
                end
            end
            merged[mc] = pw[0] + pw[1];
            parent[pick[0]] = n + mc;
            parent[pick[1]] = n + mc;
            mc++;
        end
        // depths from the root down, parents have larger ids
        depth[2*n-2] = 0;
        for (i = 2*n-2; i > 0; i--) depth[i-1] = depth[parent[i-1]] + 1;
        shortest = depth[0];
        longest = depth[0];
        for (i = 1; i < n; i++) begin
            if (depth[i] < shortest) shortest = depth[i];
            if (depth[i] > longest) longest = depth[i];
        end
    endfunction

    // offer one weight transaction, update the prediction on acceptance
    task automatic send_weight(input logic [hclb_pkg::IN_W-1:0] w, input logic lst,
                               input bit typed = 0, input lengths_t want = '0);
        int       gap;
        int       lo, hi;
        lengths_t r;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_weight <= w;
        s_last <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (loaded_weights.size() < CAPACITY) loaded_weights.push_back(w);
        else set_overflow = 1'b1;
        if (lst) begin
            huffman_lengths(loaded_weights, lo, hi);
            r.count = hclb_pkg::SYM_W'(loaded_weights.size());
            r.shortest = hclb_pkg::LEN_W'(lo);
            r.longest = hclb_pkg::LEN_W'(hi);
            r.ovf = set_overflow;
            pending_lengths.push_back(typed ? want : r);
            loaded_weights.delete();
            set_overflow = 1'b0;
        end
    endtask

    task automatic drain_results();
        while (pending_lengths.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [hclb_pkg::IN_W-1:0] random_weight();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 7);
            2: return 32'hFFFF_FFFF - $urandom_range(0, 7);
            default: return $urandom() << $urandom_range(0, 31);
        endcase
    endfunction

    // result receiver with random stalls and one long hold-off
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        lengths_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_lengths.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result count=%0d min=%0d max=%0d ovf=%0b",
                             m_symbol_count, m_min_length, m_max_length, m_overflow);
            end else begin
                want = pending_lengths[0];
                pending_lengths.delete(0);
                if (m_symbol_count !== want.count || m_min_length !== want.shortest ||
                    m_max_length !== want.longest || m_overflow !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 want.count, want.shortest, want.longest, want.ovf,
                                 m_symbol_count, m_min_length, m_max_length, m_overflow);
                end
            end
        end
    end

    // run limit
    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus
    initial begin
        stim_row_t rows[$];
        int        i, len, sent;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        rows = '{
            '{32'd0,          1'b1, 1'b1, '{11'd1, 10'd0, 10'd0, 1'b0}},
            '{32'hFFFF_FFFF,  1'b1, 1'b1, '{11'd1, 10'd0, 10'd0, 1'b0}},
            '{32'd0,          1'b0, 1'b0, '0},
            '{32'hFFFF_FFFF,  1'b1, 1'b1, '{11'd2, 10'd1, 10'd1, 1'b0}},
            '{32'd5,          1'b0, 1'b0, '0},
            '{32'd5,          1'b0, 1'b0, '0},
            '{32'd5,          1'b1, 1'b1, '{11'd3, 10'd1, 10'd2, 1'b0}},
            '{32'd1,          1'b0, 1'b0, '0},
            '{32'd1,          1'b0, 1'b0, '0},
            '{32'd2,          1'b1, 1'b0, '0},
            '{32'hAAAA_AAAA,  1'b0, 1'b0, '0},
            '{32'h5555_5555,  1'b0, 1'b0, '0},
            '{32'd8,          1'b0, 1'b0, '0},
            '{32'd4,          1'b0, 1'b0, '0},
            '{32'd2,          1'b0, 1'b0, '0},
            '{32'd1,          1'b1, 1'b0, '0},
            '{32'h8000_0000,  1'b0, 1'b0, '0},
            '{32'h8000_0000,  1'b0, 1'b0, '0},
            '{32'd1,          1'b1, 1'b0, '0}
        };
        foreach (rows[r]) send_weight(rows[r].weight, rows[r].last, rows[r].typed, rows[r].want);

        // capacity exceeded: the dropped item carries last and still ends the set
        for (i = 0; i < CAPACITY; i++) send_weight(i, 1'b0);
        send_weight(32'hFFFF_FFFF, 1'b1);

        // sender pauses until every result is back
        s_valid <= 1'b0;
        @(posedge aclk);
        drain_results();

        // long receiver hold-off while small sets keep coming
        hold_req = 1'b1;
        for (len = 1; len <= 6; len++)
            for (i = 0; i < len; i++) send_weight(random_weight(), i == len - 1);

        // random sets
        sent = 0;
        while (sent < 400) begin
            if (sent > 340) calm = 1'b1;
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            for (i = 0; i < len; i++) send_weight(random_weight(), i == len - 1);
            sent += len;
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        drain_results();
        repeat (64) @(posedge aclk);

        if (mismatches == 0 && pending_lengths.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

FILE: sim.f
sv/hclb_pkg.sv
sv/hclb_ram.sv
sv/hclb_ctrl.sv
sv/hclb_dp.sv
sv/huffman_code_length_builder_unit.sv
bench/tb_huffman_code_length_builder_unit.sv
